[hw/rtl/mfm_pulse_interval_encoder_assert.svh]
// assertion macros for the encoder checker
`ifndef MFM_PULSE_INTERVAL_ENCODER_ASSERT_SVH
`define MFM_PULSE_INTERVAL_ENCODER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MPIE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define MPIE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/mpie_pkg.sv]
// shared types and constants for the mfm pulse interval encoder
package mpie_pkg;

  localparam int unsigned CMD_W            = 3;
  localparam int unsigned DATA_W           = 8;
  localparam int unsigned CODE_W           = 2;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned STEP_W           = 3;
  localparam int unsigned MPIE_QUEUE_DEPTH = 2;

  // command codes on the request channel
  localparam logic [CMD_W-1:0] CMD_ENCODE_CRC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SYNC_MARK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RAW_BYTE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PAD_EVEN   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CRC_PRESET = 3'd5;
  localparam logic [CMD_W-1:0] CMD_EMIT_CRC   = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_4US = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_6US = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_8US = 2'd2;

  // crc-16-ccitt
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [7:0]  SYNC_BYTE = 8'hA1;

  // flux change history patterns
  localparam logic [7:0] HIST_4US   = 8'h05;
  localparam logic [7:0] HIST_6US   = 8'h09;
  localparam logic [7:0] HIST_8US   = 8'h11;
  localparam logic [7:0] HIST_START = 8'h01;

  // index of the final step for each kind of operation
  localparam logic [STEP_W-1:0] LAST_STEP_ONE  = 3'd0;
  localparam logic [STEP_W-1:0] LAST_STEP_BYTE = 3'd3;
  localparam logic [STEP_W-1:0] LAST_STEP_CRC  = 3'd7;

  typedef enum logic [2:0] {
    OP_ENC_CRC,
    OP_ENC,
    OP_MARK,
    OP_RAW,
    OP_PAD,
    OP_PRESET,
    OP_EMIT_CRC,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] data;
    logic [STEP_W-1:0] last_step;
  } entry_t;

endpackage

[hw/rtl/mpie_if.sv]
// request, result and configuration channel interfaces

interface mpie_cmd_if;
  import mpie_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] data_byte;
  modport source (output valid, cmd, data_byte, input ready);
  modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface mpie_res_if;
  import mpie_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_byte;
  logic              last;
  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

interface mpie_cfg_if;
  import mpie_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CODE_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/mpie_queue.sv]
// small fifo of classified requests between front and back
module mpie_queue #(
  parameter int unsigned Depth = mpie_pkg::MPIE_QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  mpie_pkg::entry_t wr_entry_i,
  output logic            rd_valid_o,
  output mpie_pkg::entry_t rd_entry_o,
  input  logic            rd_pop_i
);
  import mpie_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign wr_ready_o = (count_q != CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_entry_o = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[hw/rtl/mpie_front.sv]
// request intake: classifies each command into an operation and a step count
module mpie_front (
  mpie_cmd_if.sink         cmd_i,
  output logic             q_valid_o,
  output mpie_pkg::entry_t q_entry_o,
  input  logic             q_ready_i
);
  import mpie_pkg::*;

  assign cmd_i.ready = q_ready_i;
  assign q_valid_o   = cmd_i.valid;

  // command decode
  always_comb begin
    q_entry_o.data = cmd_i.data_byte;
    unique case (cmd_i.cmd)
      CMD_ENCODE_CRC: begin
        q_entry_o.op        = OP_ENC_CRC;
        q_entry_o.last_step = LAST_STEP_BYTE;
      end
      CMD_ENCODE: begin
        q_entry_o.op        = OP_ENC;
        q_entry_o.last_step = LAST_STEP_BYTE;
      end
      CMD_SYNC_MARK: begin
        q_entry_o.op        = OP_MARK;
        q_entry_o.last_step = LAST_STEP_ONE;
      end
      CMD_RAW_BYTE: begin
        q_entry_o.op        = OP_RAW;
        q_entry_o.last_step = LAST_STEP_ONE;
      end
      CMD_PAD_EVEN: begin
        q_entry_o.op        = OP_PAD;
        q_entry_o.last_step = LAST_STEP_ONE;
      end
      CMD_CRC_PRESET: begin
        q_entry_o.op        = OP_PRESET;
        q_entry_o.last_step = LAST_STEP_ONE;
      end
      CMD_EMIT_CRC: begin
        q_entry_o.op        = OP_EMIT_CRC;
        q_entry_o.last_step = LAST_STEP_CRC;
      end
      default: begin
        q_entry_o.op        = OP_NOP;
        q_entry_o.last_step = LAST_STEP_ONE;
      end
    endcase
  end

endmodule

[hw/rtl/mpie_back.sv]
// execution: mfm encoding two bits a step, interval codes, crc, output register
module mpie_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  mpie_pkg::entry_t head_i,
  output logic             pop_o,
  mpie_res_if.source       res_o,
  mpie_cfg_if.sink         cfg_i
);
  import mpie_pkg::*;

  typedef struct packed {
    logic        prev;
    logic [7:0]  hist;
    logic [7:0]  shift;
    logic [1:0]  cnt;
  } enc_st_t;

  typedef struct packed {
    enc_st_t     st;
    logic        nv;
    logic [7:0]  nb;
  } step_res_t;

  // append one code, a full byte comes out every fourth code
  function automatic step_res_t add_code(step_res_t r, logic [CODE_W-1:0] code);
    step_res_t o;
    o          = r;
    o.st.shift = {r.st.shift[5:0], code};
    o.st.cnt   = r.st.cnt + 2'd1;
    if (o.st.cnt == 2'd0) begin
      o.nv = 1'b1;
      o.nb = o.st.shift;
    end
    return o;
  endfunction

  // one change slot into the history, match the interval on a change
  function automatic step_res_t change_slot(step_res_t r, logic chg,
                                            logic [CODE_W-1:0] c4,
                                            logic [CODE_W-1:0] c6,
                                            logic [CODE_W-1:0] c8);
    step_res_t         o;
    logic [7:0]        h;
    logic [CODE_W-1:0] code;
    logic              hit;
    o    = r;
    h    = {r.st.hist[6:0], chg};
    hit  = 1'b0;
    code = c4;
    if (chg) begin
      if (h == HIST_4US) begin
        hit  = 1'b1;
        code = c4;
      end else if (h == HIST_6US) begin
        hit  = 1'b1;
        code = c6;
      end else if (h == HIST_8US) begin
        hit  = 1'b1;
        code = c8;
      end
    end
    o.st.hist = hit ? HIST_START : h;
    if (hit) begin
      o = add_code(o, code);
    end
    return o;
  endfunction

  // mfm encode two data bits, msb first
  function automatic step_res_t enc_pair(step_res_t r, logic [1:0] pair,
                                         logic [CODE_W-1:0] c4,
                                         logic [CODE_W-1:0] c6,
                                         logic [CODE_W-1:0] c8);
    step_res_t o;
    logic      b;
    o = r;
    for (int i = 1; i >= 0; i--) begin
      b = pair[i];
      o = change_slot(o, !b && !o.st.prev, c4, c6, c8);
      o = change_slot(o, b, c4, c6, c8);
      o.st.prev = b;
    end
    return o;
  endfunction

  // crc-16-ccitt over one byte, msb first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  logic [CODE_W-1:0] code_4us_q, code_6us_q, code_8us_q;
  enc_st_t           enc_q;
  logic [15:0]       crc_q, crc_d;
  logic              odd_q;
  logic [STEP_W-1:0] step_q;
  logic              flush_q;
  logic              held_v_q, held_v_d;
  logic [7:0]        held_b_q;
  logic              out_v_q;
  logic [7:0]        out_b_q;
  logic              out_l_q;

  step_res_t         r_in, res;
  logic [7:0]        src_byte;
  logic [1:0]        pair;
  logic              is_final, push, push_last, out_free, go, flush_go;
  logic [7:0]        push_byte;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_4us_q <= 2'd1;
      code_6us_q <= 2'd2;
      code_8us_q <= 2'd3;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_CODE_4US: code_4us_q <= cfg_i.data;
        CFG_CODE_6US: code_6us_q <= cfg_i.data;
        CFG_CODE_8US: code_8us_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // source byte and bit pair of the current step
  always_comb begin
    if (head_i.op == OP_EMIT_CRC) begin
      src_byte = step_q[2] ? crc_q[7:0] : crc_q[15:8];
    end else begin
      src_byte = head_i.data;
    end
    unique case (step_q[1:0])
      2'd0:    pair = src_byte[7:6];
      2'd1:    pair = src_byte[5:4];
      2'd2:    pair = src_byte[3:2];
      default: pair = src_byte[1:0];
    endcase
  end

  // one step of the head operation
  always_comb begin
    r_in  = '{st: enc_q, nv: 1'b0, nb: 8'h00};
    res   = r_in;
    crc_d = crc_q;
    unique case (head_i.op)
      OP_ENC_CRC: begin
        res = enc_pair(r_in, pair, code_4us_q, code_6us_q, code_8us_q);
        if (step_q == '0) begin
          crc_d = crc_byte(crc_q, head_i.data);
        end
      end
      OP_ENC, OP_EMIT_CRC: begin
        res = enc_pair(r_in, pair, code_4us_q, code_6us_q, code_8us_q);
      end
      OP_MARK: begin
        res   = add_code(r_in, code_8us_q);
        res   = add_code(res, code_6us_q);
        res   = add_code(res, code_8us_q);
        res   = add_code(res, code_6us_q);
        crc_d = crc_byte(crc_q, SYNC_BYTE);
      end
      OP_RAW: begin
        res.nv = 1'b1;
        res.nb = head_i.data;
      end
      OP_PAD: begin
        res.nv = odd_q;
        res.nb = 8'h00;
      end
      OP_PRESET: begin
        crc_d = CRC_INIT;
      end
      default: ;
    endcase
  end

  // output push decision: a byte is held until it is known whether it closes the request
  always_comb begin
    is_final  = (step_q == head_i.last_step);
    push      = 1'b0;
    push_last = 1'b0;
    push_byte = held_b_q;
    held_v_d  = held_v_q;
    if (flush_q) begin
      push      = 1'b1;
      push_last = 1'b1;
    end else if (head_valid_i) begin
      if (res.nv && held_v_q) begin
        push     = 1'b1;
        held_v_d = 1'b1;
      end else if (res.nv && !is_final) begin
        held_v_d = 1'b1;
      end else if (res.nv) begin
        push      = 1'b1;
        push_last = 1'b1;
        push_byte = res.nb;
      end else if (held_v_q && is_final) begin
        push      = 1'b1;
        push_last = 1'b1;
        held_v_d  = 1'b0;
      end
    end
    out_free = !out_v_q || res_o.ready;
    go       = head_valid_i && !flush_q && (!push || out_free);
    flush_go = flush_q && out_free;
  end

  assign pop_o = go && is_final;

  // control and encoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q    <= '0;
      crc_q    <= CRC_INIT;
      odd_q    <= 1'b0;
      step_q   <= '0;
      flush_q  <= 1'b0;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (go) begin
        enc_q    <= res.st;
        crc_q    <= crc_d;
        odd_q    <= odd_q ^ res.nv;
        step_q   <= is_final ? '0 : step_q + STEP_W'(1);
        held_v_q <= held_v_d;
        flush_q  <= is_final && res.nv && held_v_q;
      end else if (flush_go) begin
        held_v_q <= 1'b0;
        flush_q  <= 1'b0;
      end
      if (push && (go || flush_go)) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // held byte and output payload
  always_ff @(posedge clk_i) begin
    if (go && res.nv) begin
      held_b_q <= res.nb;
    end
    if (push && (go || flush_go)) begin
      out_b_q <= push_byte;
      out_l_q <= push_last;
    end
  end

  assign res_o.valid    = out_v_q;
  assign res_o.out_byte = out_b_q;
  assign res_o.last     = out_l_q;

endmodule

[hw/rtl/mfm_pulse_interval_encoder.sv]
// mfm pulse interval encoder top level
// encode and crc emit requests take two data bits per cycle unless the result output stalls
// a flush step follows when the final step of a request yields a byte while another is held
// a raw or pad result passes the queue and the output register before it is valid
// the two-entry queue lets the next requests enter while the back end works or stalls
// reset is asynchronous active low and restores codes, crc and encoder state at once
module mfm_pulse_interval_encoder #(
  parameter int unsigned QueueDepth = mpie_pkg::MPIE_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mpie_cmd_if.sink   cmd_i,
  mpie_res_if.source res_o,
  mpie_cfg_if.sink   cfg_i
);
  import mpie_pkg::*;

  logic   wr_valid, wr_ready, rd_valid, rd_pop;
  entry_t wr_entry, rd_entry;

  // intake and classification
  mpie_front u_front (
    .cmd_i     (cmd_i),
    .q_valid_o (wr_valid),
    .q_entry_o (wr_entry),
    .q_ready_i (wr_ready)
  );

  // decoupling queue
  mpie_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_ready_o (wr_ready),
    .wr_entry_i (wr_entry),
    .rd_valid_o (rd_valid),
    .rd_entry_o (rd_entry),
    .rd_pop_i   (rd_pop)
  );

  // execution and result register
  mpie_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (rd_valid),
    .head_i       (rd_entry),
    .pop_o        (rd_pop),
    .res_o        (res_o),
    .cfg_i        (cfg_i)
  );

endmodule

[hw/rtl/mpie_checker.sv]
// port-level checker for the encoder and its bind
`include "mfm_pulse_interval_encoder_assert.svh"

module mpie_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // a stalled result keeps its payload
  `MPIE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last), "result changed while stalled")

  // configuration writes are never back-pressured
  `MPIE_ASSERT_IMP(a_cfg_taken, clk_i, rst_ni, cfg_valid, cfg_ready, "config write refused")

  // no result right after reset release
  `MPIE_ASSERT_IMP(a_rst_out_idle, clk_i, rst_ni, $rose(rst_ni), !out_valid, "result valid after reset")

  // empty queue takes a request right after reset release
  `MPIE_ASSERT_IMP(a_rst_in_ready, clk_i, rst_ni, $rose(rst_ni), in_ready, "request not ready after reset")

endmodule

bind mfm_pulse_interval_encoder mpie_checker u_mpie_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (cmd_i.ready),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .out_byte  (res_o.out_byte),
  .out_last  (res_o.last),
  .cfg_valid (cfg_i.valid),
  .cfg_ready (cfg_i.ready)
);

[dv/tb_top.sv]
// self-checking testbench for the mfm pulse interval encoder
module tb_top;
  import mpie_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0]  CMD_UNUSED   = 3'd7;
  localparam logic [DATA_W-1:0] PAD_BYTE     = 8'h00;
  localparam int                DRAIN_CYCLES = 40;
  localparam int                HOLD_AT      = 40;
  localparam int                HOLD_LEN     = 300;
  localparam int                CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] data;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_byte;
    logic              last;
  } flux_byte_t;

  logic clk_i;
  logic rst_ni;

  mpie_cmd_if cmd_if ();
  mpie_res_if res_if ();
  mpie_cfg_if cfg_if ();

  mfm_pulse_interval_encoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // encoder state mirrored by the predictor
  logic [CODE_W-1:0] code4_m = 2'd1;
  logic [CODE_W-1:0] code6_m = 2'd2;
  logic [CODE_W-1:0] code8_m = 2'd3;
  logic              last_data_bit = 1'b0;
  logic [7:0]        flux_hist = 8'h00;
  logic [7:0]        code_acc = 8'h00;
  logic [1:0]        code_cnt = 2'd0;
  logic [15:0]       crc_acc = CRC_INIT;
  logic              odd_bytes = 1'b0;

  logic [DATA_W-1:0] step_bytes[$];
  flux_byte_t        encoded_q[$];
  request_t          request_q[$];

  int       issued_n = 0;
  int       accepted_n;
  int       seen_n = 0;
  int       err_n = 0;
  int       cycle_n = 0;
  int       send_wait;
  logic     send_on;
  request_t cur_req;
  int       recv_wait;
  logic     recv_rdy;
  int       hold_left;
  logic     hold_done;
  flux_byte_t want;

  // ---------------------------------------------------------------- predictor

  function automatic void put_byte(input logic [7:0] b);
    step_bytes.push_back(b);
    odd_bytes = ~odd_bytes;
  endfunction

  function automatic void ccitt_shift(input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb      = crc_acc[15] ^ d[i];
      crc_acc = {crc_acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
  endfunction

  function automatic void pack_code(input logic [1:0] code);
    code_acc = {code_acc[5:0], code};
    code_cnt = code_cnt + 2'd1;
    if (code_cnt == 2'd0) put_byte(code_acc);
  endfunction

  // one flux slot; a change closes the interval since the previous change
  function automatic void note_slot(input logic chg);
    logic [1:0] code;
    flux_hist = {flux_hist[6:0], chg};
    if (!chg || flux_hist == 8'h00 || flux_hist == HIST_START) return;
    case (flux_hist)
      HIST_4US: code = code4_m;
      HIST_6US: code = code6_m;
      HIST_8US: code = code8_m;
      default: return;
    endcase
    flux_hist = HIST_START;
    pack_code(code);
  endfunction

  // mfm: clock change only between two zero bits, data change on a one
  function automatic void mfm_byte(input logic [7:0] v);
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        note_slot(1'b0);
        note_slot(1'b1);
      end else if (last_data_bit) begin
        note_slot(1'b0);
        note_slot(1'b0);
      end else begin
        note_slot(1'b1);
        note_slot(1'b0);
      end
      last_data_bit = v[i];
    end
  endfunction

  function automatic void predict_encoder_output(input logic [CMD_W-1:0] op,
                                                 input logic [DATA_W-1:0] value);
    logic [15:0] crc_snap;
    step_bytes.delete();
    case (op)
      CMD_ENCODE_CRC: begin
        ccitt_shift(value);
        mfm_byte(value);
      end
      CMD_ENCODE: mfm_byte(value);
      CMD_SYNC_MARK: begin
        pack_code(code8_m);
        pack_code(code6_m);
        pack_code(code8_m);
        pack_code(code6_m);
        ccitt_shift(SYNC_BYTE);
      end
      CMD_RAW_BYTE: put_byte(value);
      CMD_PAD_EVEN: if (odd_bytes) put_byte(PAD_BYTE);
      CMD_CRC_PRESET: crc_acc = CRC_INIT;
      CMD_EMIT_CRC: begin
        crc_snap = crc_acc;
        mfm_byte(crc_snap[15:8]);
        mfm_byte(crc_snap[7:0]);
      end
      default: ;
    endcase
    foreach (step_bytes[k])
      encoded_q.push_back('{out_byte: step_bytes[k], last: k == step_bytes.size() - 1});
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int queue_req(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] value);
    request_q.push_back('{cmd: op, data: value});
    issued_n++;
    return (op == CMD_UNUSED) ? 0 : 1;
  endfunction

  // gap draw with calm stretches where nobody idles
  function automatic int pick_wait(input int n, input int span);
    if ((n / span) % 2 == 1) return 0;
    return $urandom_range(0, 18);
  endfunction

  // mostly sector-like records with random content, the rest noise
  task automatic add_traffic(input int target);
    int added;
    int k;
    added = 0;
    while (added < target) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 2) == 0)
          added += queue_req(CMD_RAW_BYTE, DATA_W'($urandom_range(0, 255)));
        added += queue_req(CMD_CRC_PRESET, DATA_W'($urandom_range(0, 255)));
        repeat (3) added += queue_req(CMD_SYNC_MARK, DATA_W'($urandom_range(0, 255)));
        k = $urandom_range(1, 4);
        repeat (k) begin
          if ($urandom_range(0, 4) == 0)
            added += queue_req(CMD_ENCODE, DATA_W'($urandom_range(0, 255)));
          else
            added += queue_req(CMD_ENCODE_CRC, DATA_W'($urandom_range(0, 255)));
        end
        added += queue_req(CMD_EMIT_CRC, DATA_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0)
          added += queue_req(CMD_PAD_EVEN, DATA_W'($urandom_range(0, 255)));
      end else begin
        k = $urandom_range(1, 3);
        repeat (k) added += queue_req(CMD_W'($urandom_range(0, 7)),
                                      DATA_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // wait until every request is taken and every result has come back
  task automatic settle();
    do @(posedge clk_i); while (accepted_n != issued_n || encoded_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_codes(input logic [1:0] c4, input logic [1:0] c6, input logic [1:0] c8);
    logic [CFG_IDX_W-1:0] idx[3];
    logic [CODE_W-1:0]    vals[3];
    idx[0]  = CFG_CODE_4US;
    idx[1]  = CFG_CODE_6US;
    idx[2]  = CFG_CODE_8US;
    vals[0] = c4;
    vals[1] = c6;
    vals[2] = c8;
    for (int i = 0; i < 3; i++) begin
      cfg_if.index <= idx[i];
      cfg_if.data  <= vals[i];
      cfg_if.valid <= 1'b1;
      do @(posedge clk_i); while (!cfg_if.ready);
      case (idx[i])
        CFG_CODE_4US: code4_m = vals[i];
        CFG_CODE_6US: code6_m = vals[i];
        CFG_CODE_8US: code8_m = vals[i];
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- clock, reset, sequence

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // timeout guard
  always @(posedge clk_i) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int dummy;
    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.cmd       = '0;
    cmd_if.data_byte = '0;
    res_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first change after reset, extremes, every command, padding both ways
    dummy = queue_req(CMD_ENCODE, 8'h00);
    dummy = queue_req(CMD_ENCODE_CRC, 8'hFF);
    dummy = queue_req(CMD_ENCODE_CRC, 8'h00);
    dummy = queue_req(CMD_UNUSED, 8'hFF);
    dummy = queue_req(CMD_RAW_BYTE, 8'hFF);
    dummy = queue_req(CMD_PAD_EVEN, 8'h00);
    dummy = queue_req(CMD_PAD_EVEN, 8'hFF);
    dummy = queue_req(CMD_RAW_BYTE, 8'h00);
    dummy = queue_req(CMD_PAD_EVEN, 8'hAA);
    dummy = queue_req(CMD_CRC_PRESET, 8'h00);
    repeat (3) dummy = queue_req(CMD_SYNC_MARK, 8'h00);
    dummy = queue_req(CMD_ENCODE_CRC, 8'hFE);
    dummy = queue_req(CMD_ENCODE_CRC, 8'h55);
    dummy = queue_req(CMD_ENCODE, 8'hAA);
    dummy = queue_req(CMD_EMIT_CRC, 8'h00);
    dummy = queue_req(CMD_PAD_EVEN, 8'h00);
    dummy = queue_req(CMD_CRC_PRESET, 8'hFF);
    dummy = queue_req(CMD_EMIT_CRC, 8'hFF);
    dummy = queue_req(CMD_ENCODE, 8'h80);
    dummy = queue_req(CMD_ENCODE, 8'h01);
    add_traffic(90);
    settle();

    // code settings: both extremes, then random ones
    write_codes(2'd0, 2'd0, 2'd0);
    add_traffic(40);
    settle();
    write_codes(2'd3, 2'd3, 2'd3);
    add_traffic(40);
    settle();
    write_codes(CODE_W'($urandom_range(0, 3)), CODE_W'($urandom_range(0, 3)),
                CODE_W'($urandom_range(0, 3)));
    add_traffic(50);
    settle();
    write_codes(CODE_W'($urandom_range(0, 3)), CODE_W'($urandom_range(0, 3)),
                CODE_W'($urandom_range(0, 3)));
    add_traffic(40);
    settle();

    if (err_n == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------------------------------------------------------- request driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid     <= 1'b0;
      cmd_if.cmd       <= '0;
      cmd_if.data_byte <= '0;
      accepted_n       <= 0;
      send_wait        = 0;
      send_on          = 1'b0;
    end else begin
      if (send_on && cmd_if.ready) begin
        predict_encoder_output(cur_req.cmd, cur_req.data);
        accepted_n <= accepted_n + 1;
        send_on   = 1'b0;
        send_wait = pick_wait(accepted_n, 30);
      end
      if (!send_on) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (request_q.size() != 0) begin
          cur_req = request_q.pop_front();
          cmd_if.cmd       <= cur_req.cmd;
          cmd_if.data_byte <= cur_req.data;
          send_on = 1'b1;
        end
      end
      cmd_if.valid <= send_on;
    end
  end

  // long receiver hold-off so the request queue backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_n == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------- result monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_wait    = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        seen_n++;
        if (encoded_q.size() == 0) begin
          $display("%0t: result with none expected: byte %h last %b",
                   $time, res_if.out_byte, res_if.last);
          err_n++;
        end else begin
          want = encoded_q.pop_front();
          if (res_if.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h",
                     $time, want.out_byte, res_if.out_byte);
            err_n++;
          end
          if (res_if.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, res_if.last);
            err_n++;
          end
        end
        recv_wait = pick_wait(seen_n, 50);
      end
      if (hold_left != 0) begin
        recv_rdy = 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        recv_rdy = 1'b0;
      end else begin
        recv_rdy = 1'b1;
      end
      res_if.ready <= recv_rdy;
    end
  end

endmodule
